// ----- hw/rtl/mcsc_pkg.sv -----
package mcsc_pkg;

  localparam int unsigned SENSOR_COUNT_DEF = 4;

  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  typedef enum logic [1:0] {
    ACT_COMMAND = 2'd0,
    ACT_RANGE   = 2'd1,
    ACT_BATTERY = 2'd2
  } action_e;

  typedef enum logic [7:0] {
    CMD_NOP     = 8'd0,
    CMD_FORWARD = 8'd1,
    CMD_BACK    = 8'd2,
    CMD_LEFT    = 8'd3,
    CMD_RIGHT   = 8'd4,
    CMD_STOP    = 8'd5,
    CMD_BRAKE   = 8'd6
  } command_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DRIVE_LIMIT  = 3'd0,
    CFG_RANGE_MIN    = 3'd1,
    CFG_RANGE_MAX    = 3'd2,
    CFG_NEAR         = 3'd3,
    CFG_BATT_CRIT    = 3'd4
  } cfg_index_e;

  localparam logic [11:0] DRIVE_LIMIT_RST = 12'd3000;
  localparam logic [12:0] RANGE_MIN_RST   = 13'd30;
  localparam logic [12:0] RANGE_MAX_RST   = 13'd1300;
  localparam logic [12:0] NEAR_RST        = 13'd30;
  localparam logic [13:0] BATT_CRIT_RST   = 14'd6000;
  localparam logic [12:0] RANGE_RST       = 13'd5000;

  // Battery scaling: mv = ((adc * 3300) >> 12) * 3128 / 1000, clipped.
  localparam logic [11:0] ADC_SCALE    = 12'd3300;
  localparam logic [11:0] DIVIDER_GAIN = 12'd3128;
  // Reciprocal of 1000 scaled by 2^34, rounded up; exact for 24-bit operands.
  localparam logic [24:0] RECIP_1000   = 25'd17179870;
  localparam logic [13:0] MV_CLIP      = 14'd12600;

  typedef struct packed {
    logic [11:0] adc_raw;
    logic        range_ok;
    logic [15:0] range_raw;
    logic [1:0]  sensor_index;
    logic [15:0] target_b;
    logic [15:0] target_a;
    logic [7:0]  command;
    logic [1:0]  action;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [14:0] mv_quot;
  } conv_item_t;

  typedef struct packed {
    logic [12:0] range_mm;
    logic [13:0] battery_mv_out;
    logic        battery_low;
    logic        stop_latched;
    logic [11:0] drive_b;
    logic [11:0] drive_a;
  } result_t;

endpackage

// ----- hw/rtl/mcsc_batt_pipe.sv -----
module mcsc_batt_pipe import mcsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  item_t      in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output conv_item_t out_data_o
);

  logic v0_q, v1_q, v2_q, v3_q;
  logic v0_d, v1_d, v2_d, v3_d;
  logic rdy0, rdy1, rdy2, rdy3;

  item_t       s0_q;
  item_t       s1_item_q;
  logic [11:0] s1_q1_q;
  item_t       s2_item_q;
  logic [23:0] s2_q2_q;
  conv_item_t  s3_q;

  logic [23:0] prod1;
  logic [23:0] prod2;
  logic [48:0] prod3;

  assign rdy3 = !v3_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign v0_d = rdy0 ? in_valid_i : v0_q;
  assign v1_d = rdy1 ? v0_q : v1_q;
  assign v2_d = rdy2 ? v1_q : v2_q;
  assign v3_d = rdy3 ? v2_q : v3_q;

  assign prod1 = 24'(s0_q.adc_raw) * 24'(ADC_SCALE);
  assign prod2 = 24'(s1_q1_q) * 24'(DIVIDER_GAIN);
  assign prod3 = 49'(s2_q2_q) * 49'(RECIP_1000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      s0_q <= in_data_i;
    end
    if (rdy1 && v0_q) begin
      s1_item_q <= s0_q;
      s1_q1_q   <= prod1[23:12];
    end
    if (rdy2 && v1_q) begin
      s2_item_q <= s1_item_q;
      s2_q2_q   <= prod2;
    end
    if (rdy3 && v2_q) begin
      s3_q.item    <= s2_item_q;
      s3_q.mv_quot <= prod3[48:34];
    end
  end

  assign in_ready_o  = rdy0;
  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

endmodule

// ----- hw/rtl/mcsc_ctrl.sv -----
module mcsc_ctrl import mcsc_pkg::*; #(
  parameter int unsigned SensorCount = SENSOR_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  conv_item_t             in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output result_t                out_data_o
);

  logic [11:0] drive_limit_q;
  logic [12:0] range_min_q;
  logic [12:0] range_max_q;
  logic [12:0] near_q;
  logic [13:0] batt_crit_q;

  logic        stop_q, stop_d;
  logic [11:0] duty_a_q, duty_a_d;
  logic [11:0] duty_b_q, duty_b_d;
  logic [12:0] ranges_q [SensorCount];
  logic [12:0] ranges_d [SensorCount];
  logic [13:0] batt_mv_q, batt_mv_d;
  logic        low_q, low_d;
  logic [12:0] range_out;

  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    in_fire;
  item_t   it;

  function automatic logic [11:0] clamp_duty(input logic [15:0] req, input logic [11:0] lim);
    clamp_duty = (req > {4'd0, lim}) ? lim : req[11:0];
  endfunction

  assign it         = in_data_i.item;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    logic [12:0] d;
    logic [13:0] mv;
    logic        all_close;
    stop_d    = stop_q;
    duty_a_d  = duty_a_q;
    duty_b_d  = duty_b_q;
    batt_mv_d = batt_mv_q;
    low_d     = low_q;
    range_out = '0;
    d         = '0;
    mv        = '0;
    for (int i = 0; i < int'(SensorCount); i++) begin
      ranges_d[i] = ranges_q[i];
    end

    if (it.action == ACT_COMMAND) begin
      if (stop_q && it.command != CMD_NOP) begin
        duty_a_d = '0;
        duty_b_d = '0;
      end else begin
        case (it.command) inside
          CMD_FORWARD: begin
            duty_a_d = clamp_duty(it.target_a, drive_limit_q);
            duty_b_d = clamp_duty(it.target_b, drive_limit_q);
          end
          CMD_LEFT: begin
            duty_a_d = clamp_duty(it.target_a, drive_limit_q);
            duty_b_d = '0;
          end
          CMD_RIGHT: begin
            duty_a_d = '0;
            duty_b_d = clamp_duty(it.target_b, drive_limit_q);
          end
          CMD_STOP: begin
            duty_a_d = '0;
            duty_b_d = '0;
            stop_d   = 1'b1;
          end
          CMD_BACK, CMD_BRAKE: begin
            duty_a_d = '0;
            duty_b_d = '0;
          end
          default: begin
          end
        endcase
      end
    end else if (it.action == ACT_RANGE) begin
      if (32'(it.sensor_index) < SensorCount) begin
        if (!it.range_ok || it.range_raw < {3'd0, range_min_q}
            || it.range_raw > {3'd0, range_max_q}) begin
          d = range_max_q;
        end else begin
          d = it.range_raw[12:0];
        end
        for (int i = 0; i < int'(SensorCount); i++) begin
          if (32'(it.sensor_index) == 32'(i)) begin
            ranges_d[i] = d;
          end
        end
        range_out = d;
      end
    end else if (it.action == ACT_BATTERY) begin
      mv = (in_data_i.mv_quot > {1'b0, MV_CLIP}) ? MV_CLIP : in_data_i.mv_quot[13:0];
      batt_mv_d = mv;
      low_d     = mv < batt_crit_q;
    end

    all_close = 1'b1;
    for (int i = 0; i < int'(SensorCount); i++) begin
      if (ranges_d[i] > near_q) begin
        all_close = 1'b0;
      end
    end
    if (!stop_d && all_close) begin
      duty_a_d = '0;
      duty_b_d = '0;
      stop_d   = 1'b1;
    end
  end

  assign out_valid_d = in_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_limit_q <= DRIVE_LIMIT_RST;
      range_min_q   <= RANGE_MIN_RST;
      range_max_q   <= RANGE_MAX_RST;
      near_q        <= NEAR_RST;
      batt_crit_q   <= BATT_CRIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_DRIVE_LIMIT: drive_limit_q <= cfg_data_i[11:0];
        CFG_RANGE_MIN:   range_min_q   <= cfg_data_i[12:0];
        CFG_RANGE_MAX:   range_max_q   <= cfg_data_i[12:0];
        CFG_NEAR:        near_q        <= cfg_data_i[12:0];
        CFG_BATT_CRIT:   batt_crit_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q      <= 1'b0;
      duty_a_q    <= '0;
      duty_b_q    <= '0;
      batt_mv_q   <= '0;
      low_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(SensorCount); i++) begin
        ranges_q[i] <= RANGE_RST;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        stop_q    <= stop_d;
        duty_a_q  <= duty_a_d;
        duty_b_q  <= duty_b_d;
        batt_mv_q <= batt_mv_d;
        low_q     <= low_d;
        for (int i = 0; i < int'(SensorCount); i++) begin
          ranges_q[i] <= ranges_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q.drive_a        <= duty_a_d;
      out_q.drive_b        <= duty_b_d;
      out_q.stop_latched   <= stop_d;
      out_q.battery_low    <= low_d;
      out_q.battery_mv_out <= batt_mv_d;
      out_q.range_mm       <= range_out;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_stop_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("Emergency stop latch was released.");

  a_stop_zeroes_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stop_q) |-> (duty_a_q == '0 && duty_b_q == '0))
    else $error("Drives not zero when the stop latched.");

  a_stopped_command: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && stop_q && it.action == ACT_COMMAND && it.command != CMD_NOP)
    |=> (out_q.drive_a == '0 && out_q.drive_b == '0 && out_q.stop_latched))
    else $error("Command while stopped did not force the drives to zero.");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && it.action != ACT_RANGE) |=> (out_q.range_mm == '0))
    else $error("Range output not zero for a non-range transaction.");

endmodule

// ----- hw/rtl/motor_command_safety_controller_unit.sv -----
// Motor command safety controller. Each transaction on the slave side is a drive
// command, a range sample or a battery sample, selected by tuser, and produces
// exactly one result transaction carrying the drive duties, the emergency stop
// and battery flags, the battery voltage and the stored range. A new transaction
// is accepted on every cycle while the result side does not stall; the result is
// offered after the transaction has passed an input register, three register
// stages for the battery scaling multipliers and the result register where the
// state is updated. Range state is held in flip-flops and is set at reset, so no
// clearing pass is needed. The user must write configuration registers through
// the write port only while no transaction is in flight; the block itself does
// not enforce this.
module motor_command_safety_controller_unit import mcsc_pkg::*; #(
  parameter int unsigned SensorCount = SENSOR_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // command, target_a, target_b, sensor_index, range_raw, range_ok, adc_raw, zero pad
  input  logic [71:0]            s_axis_tdata_i,
  // action
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // drive_a, drive_b, stop_latched, battery_low, battery_mv_out, range_mm, zero pad
  output logic [55:0]            m_axis_tdata_o
);

  item_t      in_item;
  conv_item_t conv_item;
  logic       conv_valid;
  logic       conv_ready;
  result_t    res;

  assign in_item.action       = s_axis_tuser_i;
  assign in_item.command      = s_axis_tdata_i[7:0];
  assign in_item.target_a     = s_axis_tdata_i[23:8];
  assign in_item.target_b     = s_axis_tdata_i[39:24];
  assign in_item.sensor_index = s_axis_tdata_i[41:40];
  assign in_item.range_raw    = s_axis_tdata_i[57:42];
  assign in_item.range_ok     = s_axis_tdata_i[58];
  assign in_item.adc_raw      = s_axis_tdata_i[70:59];

  mcsc_batt_pipe u_batt_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (in_item),
    .out_valid_o (conv_valid),
    .out_ready_i (conv_ready),
    .out_data_o  (conv_item)
  );

  mcsc_ctrl #(
    .SensorCount (SensorCount)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (conv_valid),
    .in_ready_o  (conv_ready),
    .in_data_i   (conv_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata_o = {3'd0, res};

endmodule

// ----- tb/sv/motor_command_safety_controller_unit_tb.sv -----
module motor_command_safety_controller_unit_tb import mcsc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CHUNK_ITEMS = 150;
  localparam int unsigned CHUNKS = 12;
  localparam int unsigned LATCH_CHUNK = 10;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;

  logic [11:0] drive_limit_cfg = DRIVE_LIMIT_RST;
  logic [12:0] range_min_cfg = RANGE_MIN_RST;
  logic [12:0] range_max_cfg = RANGE_MAX_RST;
  logic [12:0] near_cfg = NEAR_RST;
  logic [13:0] batt_crit_cfg = BATT_CRIT_RST;

  logic stop_st = 1'b0;
  logic [11:0] duty_a_st = '0;
  logic [11:0] duty_b_st = '0;
  logic [12:0] ranges_st [SENSOR_COUNT_DEF];
  logic [13:0] batt_mv_st = '0;
  logic batt_low_st = 1'b0;

  item_t pending_items_q [$];
  result_t expected_status_q [$];
  item_t cur_item;
  int tx_idle_pct = 17;
  int rx_idle_pct = 85;
  int hold_left = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  motor_command_safety_controller_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #6ns clk_i = ~clk_i;

  function automatic logic [11:0] clamp_duty(logic [15:0] req);
    return (req > 16'(drive_limit_cfg)) ? drive_limit_cfg : req[11:0];
  endfunction

  function automatic result_t predict_controller_step(item_t it);
    result_t r;
    logic [15:0] dist_mm;
    int unsigned mv;
    logic all_close;
    r = '0;
    case (it.action)
      ACT_COMMAND: begin
        if (stop_st && it.command != CMD_NOP) begin
          duty_a_st = '0;
          duty_b_st = '0;
        end else begin
          case (it.command) inside
            CMD_FORWARD: begin
              duty_a_st = clamp_duty(it.target_a);
              duty_b_st = clamp_duty(it.target_b);
            end
            CMD_BACK, CMD_BRAKE: begin
              duty_a_st = '0;
              duty_b_st = '0;
            end
            CMD_LEFT: begin
              duty_a_st = clamp_duty(it.target_a);
              duty_b_st = '0;
            end
            CMD_RIGHT: begin
              duty_a_st = '0;
              duty_b_st = clamp_duty(it.target_b);
            end
            CMD_STOP: begin
              duty_a_st = '0;
              duty_b_st = '0;
              stop_st = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ACT_RANGE: begin
        dist_mm = it.range_raw;
        if (!it.range_ok || dist_mm < 16'(range_min_cfg) || dist_mm > 16'(range_max_cfg)) begin
          dist_mm = 16'(range_max_cfg);
        end
        ranges_st[it.sensor_index] = dist_mm[12:0];
        r.range_mm = dist_mm[12:0];
      end
      ACT_BATTERY: begin
        mv = it.adc_raw;
        mv = mv * 3300 / 4096 * 3128 / 1000;
        if (mv > 12600) begin
          mv = 12600;
        end
        batt_mv_st = mv[13:0];
        batt_low_st = (mv < batt_crit_cfg);
      end
      default: ;
    endcase
    all_close = 1'b1;
    foreach (ranges_st[i]) begin
      if (ranges_st[i] > near_cfg) begin
        all_close = 1'b0;
      end
    end
    if (!stop_st && all_close) begin
      duty_a_st = '0;
      duty_b_st = '0;
      stop_st = 1'b1;
    end
    r.drive_a = duty_a_st;
    r.drive_b = duty_b_st;
    r.stop_latched = stop_st;
    r.battery_low = batt_low_st;
    r.battery_mv_out = batt_mv_st;
    return r;
  endfunction

  function automatic item_t command_item(logic [7:0] cmd, logic [15:0] ta, logic [15:0] tb);
    item_t it;
    it = '0;
    it.action = ACT_COMMAND;
    it.command = cmd;
    it.target_a = ta;
    it.target_b = tb;
    return it;
  endfunction

  function automatic item_t range_item(logic [1:0] idx, logic [15:0] raw, logic ok);
    item_t it;
    it = '0;
    it.action = ACT_RANGE;
    it.sensor_index = idx;
    it.range_raw = raw;
    it.range_ok = ok;
    return it;
  endfunction

  function automatic item_t battery_item(logic [11:0] adc);
    item_t it;
    it = '0;
    it.action = ACT_BATTERY;
    it.adc_raw = adc;
    return it;
  endfunction

  function automatic item_t random_item(bit stop_ok);
    item_t it;
    int unsigned sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) begin
      it.action = ACT_COMMAND;
    end else if (sel < 14) begin
      it.action = ACT_RANGE;
    end else if (sel < 18) begin
      it.action = ACT_BATTERY;
    end else begin
      it.action = ACT_UNUSED;
    end
    if ($urandom_range(0, 9) < 7) begin
      it.command = 8'($urandom_range(CMD_NOP, CMD_BRAKE));
    end else begin
      it.command = 8'($urandom_range(0, 255));
    end
    if (!stop_ok && it.command == CMD_STOP) begin
      it.command = CMD_FORWARD;
    end
    it.target_a = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4200));
    it.target_b = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4200));
    it.sensor_index = 2'($urandom_range(0, 3));
    it.range_ok = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0: it.range_raw = 16'($urandom_range(0, 65535));
      1: begin
        if (range_min_cfg <= range_max_cfg) begin
          it.range_raw = 16'($urandom_range(range_min_cfg, range_max_cfg));
        end else begin
          it.range_raw = 16'($urandom_range(0, 8191));
        end
      end
      2: begin
        case ($urandom_range(0, 3))
          0: it.range_raw = 16'(range_min_cfg) - 16'd1;
          1: it.range_raw = 16'(range_min_cfg);
          2: it.range_raw = 16'(range_max_cfg);
          default: it.range_raw = 16'(range_max_cfg) + 16'd1;
        endcase
      end
      default: it.range_raw = 16'($urandom_range(0, 8191));
    endcase
    if ($urandom_range(0, 15) == 0) begin
      it.adc_raw = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
    end else begin
      it.adc_raw = 12'($urandom_range(0, 4095));
    end
    return it;
  endfunction

  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_items_q.size() != 0 || expected_status_q.size() != 0 || s_tvalid);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic program_regs(logic [11:0] lim, logic [12:0] mn, logic [12:0] mx,
                              logic [12:0] nr, logic [13:0] crit);
    logic [13:0] vals [5];
    vals = '{14'(lim), 14'(mn), 14'(mx), 14'(nr), crit};
    for (int i = 0; i < 5; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_index <= cfg_index_e'(i);
      cfg_data <= vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
    drive_limit_cfg = lim;
    range_min_cfg = mn;
    range_max_cfg = mx;
    near_cfg = nr;
    batt_crit_cfg = crit;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_status_q.push_back(predict_controller_step(cur_item));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_item = pending_items_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {1'b0, cur_item[72:2]};
          s_tuser <= cur_item.action;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t got_r;
    result_t want_r;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_r = m_tdata[52:0];
        if (expected_status_q.size() == 0) begin
          $error("result transaction with no expectation waiting: %h", got_r);
          err_cnt++;
        end else begin
          want_r = expected_status_q.pop_front();
          if (got_r.drive_a !== want_r.drive_a) begin
            $error("drive_a: expected %0d, actual %0d", want_r.drive_a, got_r.drive_a);
            err_cnt++;
          end
          if (got_r.drive_b !== want_r.drive_b) begin
            $error("drive_b: expected %0d, actual %0d", want_r.drive_b, got_r.drive_b);
            err_cnt++;
          end
          if (got_r.stop_latched !== want_r.stop_latched) begin
            $error("stop_latched: expected %0d, actual %0d",
                   want_r.stop_latched, got_r.stop_latched);
            err_cnt++;
          end
          if (got_r.battery_low !== want_r.battery_low) begin
            $error("battery_low: expected %0d, actual %0d",
                   want_r.battery_low, got_r.battery_low);
            err_cnt++;
          end
          if (got_r.battery_mv_out !== want_r.battery_mv_out) begin
            $error("battery_mv_out: expected %0d, actual %0d",
                   want_r.battery_mv_out, got_r.battery_mv_out);
            err_cnt++;
          end
          if (got_r.range_mm !== want_r.range_mm) begin
            $error("range_mm: expected %0d, actual %0d", want_r.range_mm, got_r.range_mm);
            err_cnt++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("motor_command_safety_controller_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin
    item_t it;
    logic [11:0] lim;
    logic [12:0] mn;
    logic [12:0] mx;
    logic [12:0] nr;
    logic [13:0] crit;
    foreach (ranges_st[i]) begin
      ranges_st[i] = RANGE_RST;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_items_q.push_back(command_item(CMD_NOP, 16'd0, 16'd0));
    pending_items_q.push_back(command_item(CMD_FORWARD, 16'd1000, 16'd2000));
    pending_items_q.push_back(command_item(CMD_FORWARD, 16'd65535, 16'd3000));
    pending_items_q.push_back(command_item(CMD_FORWARD, 16'd3001, 16'd0));
    pending_items_q.push_back(command_item(CMD_LEFT, 16'd500, 16'd9999));
    pending_items_q.push_back(command_item(CMD_RIGHT, 16'd9999, 16'd700));
    pending_items_q.push_back(command_item(CMD_BACK, 16'd65535, 16'd65535));
    pending_items_q.push_back(command_item(CMD_FORWARD, 16'd1234, 16'd4321));
    pending_items_q.push_back(command_item(CMD_BRAKE, 16'd1, 16'd1));
    pending_items_q.push_back(command_item(CMD_FORWARD, 16'd100, 16'd200));
    pending_items_q.push_back(command_item(8'd255, 16'd4000, 16'd4000));
    pending_items_q.push_back(command_item(8'd7, 16'd50, 16'd50));
    pending_items_q.push_back(range_item(2'd0, 16'd29, 1'b1));
    pending_items_q.push_back(range_item(2'd1, 16'd30, 1'b1));
    pending_items_q.push_back(range_item(2'd2, 16'd1300, 1'b1));
    pending_items_q.push_back(range_item(2'd3, 16'd1301, 1'b1));
    pending_items_q.push_back(range_item(2'd0, 16'd500, 1'b0));
    pending_items_q.push_back(range_item(2'd3, 16'd65535, 1'b1));
    pending_items_q.push_back(range_item(2'd2, 16'd0, 1'b1));
    pending_items_q.push_back(battery_item(12'd0));
    pending_items_q.push_back(battery_item(12'd4095));
    pending_items_q.push_back(battery_item(12'd2381));
    pending_items_q.push_back(battery_item(12'd2382));
    it = command_item(CMD_FORWARD, 16'd100, 16'd100);
    it.action = ACT_UNUSED;
    pending_items_q.push_back(it);

    for (int k = 0; k < CHUNKS; k++) begin
      wait_idle();
      if (k < 4) begin
        tx_idle_pct = 17;
        rx_idle_pct = 85;
      end else if (k < 8) begin
        tx_idle_pct = 85;
        rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (k == LATCH_CHUNK) begin
        // The stop latch can only be cleared by reset, so it is set once, late in the run.
        program_regs(DRIVE_LIMIT_RST, RANGE_MIN_RST, RANGE_MAX_RST, NEAR_RST, BATT_CRIT_RST);
        pending_items_q.push_back(command_item(CMD_FORWARD, 16'd800, 16'd900));
        if ($urandom_range(0, 1) == 1) begin
          pending_items_q.push_back(command_item(CMD_STOP, 16'd0, 16'd0));
        end else begin
          for (int s = 0; s < SENSOR_COUNT_DEF; s++) begin
            pending_items_q.push_back(range_item(2'(s), 16'd30, 1'b1));
          end
        end
        pending_items_q.push_back(command_item(CMD_FORWARD, 16'd500, 16'd500));
        pending_items_q.push_back(command_item(CMD_NOP, 16'd500, 16'd500));
        pending_items_q.push_back(command_item(CMD_STOP, 16'd0, 16'd0));
        pending_items_q.push_back(range_item(2'd2, 16'd1000, 1'b1));
        it = command_item(CMD_LEFT, 16'd100, 16'd100);
        it.action = ACT_UNUSED;
        pending_items_q.push_back(it);
        wait_idle();
      end
      case (k)
        0: {lim, mn, mx, nr, crit} = {12'd4095, 13'd30, 13'd8191, 13'd29, 14'd16383};
        1: {lim, mn, mx, nr, crit} = {12'd0, 13'd8191, 13'd8191, 13'd0, 14'd0};
        10: {lim, mn, mx, nr, crit} = {12'd4095, 13'd0, 13'd8191, 13'd8191, 14'd16383};
        11: {lim, mn, mx, nr, crit} = {12'd0, 13'd8191, 13'd0, 13'd0, 14'd0};
        default: begin
          lim = 12'($urandom_range(0, 4095));
          mn = 13'($urandom_range(30, 2000));
          if ($urandom_range(0, 3) == 0) begin
            mx = 13'($urandom_range(30, 8191));
          end else begin
            mx = 13'($urandom_range(mn, 8191));
          end
          nr = 13'($urandom_range(0, 29));
          crit = 14'($urandom_range(2000, 10000));
        end
      endcase
      program_regs(lim, mn, mx, nr, crit);
      if (k == 8) begin
        hold_left = 400;
      end
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pending_items_q.push_back(random_item(k >= LATCH_CHUNK));
      end
    end

    wait_idle();
    repeat (12) @(posedge clk_i);
    if (err_cnt == 0 && expected_status_q.size() == 0) begin
      $display("motor_command_safety_controller_unit_tb passed");
    end else begin
      $display("motor_command_safety_controller_unit_tb failed");
    end
    $finish;
  end

endmodule
